// File: design/tci_pkg.sv
// tci_pkg: shared types, codes and constants of the tsetlin clause inference block
// no dependencies, compiled first
package tci_pkg;

    localparam int CLAUSE_COUNT_DEF  = 64;
    localparam int LITERAL_COUNT_DEF = 64;
    localparam int WORD_W            = 64;
    localparam int IDX_FIELD_W       = 6;
    localparam int THR_W             = 6;
    localparam int VOTE_W            = 7;
    localparam int FIFO_DEPTH        = 2;
    localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;

    localparam logic [1:0] MODE_LOAD          = 2'd0;
    localparam logic [1:0] MODE_EVAL_UPDATE   = 2'd1;
    localparam logic [1:0] MODE_EVAL_PREDICT  = 2'd2;

    localparam logic             REG_VOTE_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0] THRESHOLD_RESET    = 6'd16;

    localparam logic [WORD_W-1:0] EVEN_CLAUSES = {2{32'h55555555}};
    localparam logic [WORD_W-1:0] ODD_CLAUSES  = {2{32'haaaaaaaa}};

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_EVAL_UPDATE,
        OP_EVAL_PREDICT
    } tci_op_e;

    typedef struct packed {
        logic [1:0]             mode;
        logic [IDX_FIELD_W-1:0] clause_index;
        logic [WORD_W-1:0]      include_bits;
        logic [WORD_W-1:0]      literal_bits;
    } tci_in_t;

    typedef struct packed {
        logic signed [VOTE_W-1:0] class_vote;
        logic [WORD_W-1:0]        clauses_fired;
    } tci_out_t;

    typedef struct packed {
        tci_op_e                op;
        logic [IDX_FIELD_W-1:0] idx;
        logic [WORD_W-1:0]      data;
    } tci_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tci_fifo_stat_t;

endpackage

// File: design/tci_front.sv
// tci_front: accepts input words and turns them into load or evaluate commands
// depends on tci_pkg
module tci_front #(
    parameter int CLAUSE_COUNT = tci_pkg::CLAUSE_COUNT_DEF
) (
    input  logic                    s_valid,
    output logic                    s_ready,
    input  tci_pkg::tci_in_t        s_data,
    input  tci_pkg::tci_fifo_stat_t fifo_stat,
    output logic                    push,
    output tci_pkg::tci_cmd_t       cmd
);
    import tci_pkg::*;

    logic cmd_ok;

    assign s_ready = !fifo_stat.full;

    always_comb begin
        cmd_ok   = 1'b0;
        cmd.op   = OP_LOAD;
        cmd.idx  = s_data.clause_index;
        cmd.data = s_data.literal_bits;
        unique case (s_data.mode)
            MODE_LOAD: begin
                cmd_ok   = ({1'b0, s_data.clause_index} < (IDX_FIELD_W + 1)'(CLAUSE_COUNT));
                cmd.op   = OP_LOAD;
                cmd.data = s_data.include_bits;
            end
            MODE_EVAL_UPDATE: begin
                cmd_ok = 1'b1;
                cmd.op = OP_EVAL_UPDATE;
            end
            MODE_EVAL_PREDICT: begin
                cmd_ok = 1'b1;
                cmd.op = OP_EVAL_PREDICT;
            end
            default: begin
                cmd_ok = 1'b0;
            end
        endcase
    end

    // unused mode and out-of-range loads are taken and dropped
    assign push = s_valid && s_ready && cmd_ok;

endmodule

// File: design/tci_fifo.sv
// tci_fifo: short command queue between front and back
// depends on tci_pkg
module tci_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  tci_pkg::tci_cmd_t       push_cmd,
    input  logic                    pop,
    output tci_pkg::tci_cmd_t       head_cmd,
    output tci_pkg::tci_fifo_stat_t stat
);
    import tci_pkg::*;

    tci_cmd_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    assign stat.full  = (count_reg == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: design/tci_back.sv
// tci_back: include store, parallel clause evaluation and vote pipeline
// depends on tci_pkg
module tci_back #(
    parameter int CLAUSE_COUNT  = tci_pkg::CLAUSE_COUNT_DEF,
    parameter int LITERAL_COUNT = tci_pkg::LITERAL_COUNT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cmd_valid,
    input  tci_pkg::tci_cmd_t         cmd,
    output logic                      cmd_pop,
    input  logic [tci_pkg::THR_W-1:0] vote_threshold,
    output logic                      m_valid,
    input  logic                      m_ready,
    output tci_pkg::tci_out_t         m_data
);
    import tci_pkg::*;

    localparam int IDX_W    = $clog2(CLAUSE_COUNT);
    localparam int GROUPS   = 4;
    localparam int GROUP_W  = WORD_W / GROUPS;
    localparam int PAIRS    = GROUP_W / 2;
    localparam int PART_W   = $clog2(PAIRS) + 1;
    localparam int SUM_W    = $clog2(WORD_W / 2) + 1;

    logic [LITERAL_COUNT-1:0] store_reg [CLAUSE_COUNT];

    logic              is_load, is_eval, is_predict;
    logic              out_ready, b_ready, a_ready;
    logic [WORD_W-1:0] fired_next;

    logic              a_vld_reg;
    logic [WORD_W-1:0] fired_a_reg;

    logic              b_vld_reg;
    logic [WORD_W-1:0] fired_b_reg;
    logic [PART_W-1:0] even_part_reg [GROUPS];
    logic [PART_W-1:0] odd_part_reg  [GROUPS];
    logic [PART_W-1:0] even_part_next [GROUPS];
    logic [PART_W-1:0] odd_part_next  [GROUPS];

    logic                     m_valid_reg;
    tci_out_t                 m_data_reg;
    logic [SUM_W-1:0]         even_sum, odd_sum;
    logic signed [VOTE_W-1:0] vote_raw, lim, neg_lim, vote_next;

    assign is_load    = (cmd.op == OP_LOAD);
    assign is_predict = (cmd.op == OP_EVAL_PREDICT);
    assign is_eval    = (cmd.op == OP_EVAL_UPDATE) || is_predict;

    assign out_ready = !m_valid_reg || m_ready;
    assign b_ready   = !b_vld_reg || out_ready;
    assign a_ready   = !a_vld_reg || b_ready;
    assign cmd_pop   = cmd_valid && (is_load || a_ready);

    // every clause checked against the literal word at once
    always_comb begin
        logic [LITERAL_COUNT-1:0] lits;
        lits       = cmd.data[LITERAL_COUNT-1:0];
        fired_next = '0;
        for (int j = 0; j < CLAUSE_COUNT; j++) begin
            fired_next[j] = !(|(store_reg[j] & ~lits)) && !(is_predict && !(|store_reg[j]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < CLAUSE_COUNT; j++) begin
                store_reg[j] <= '0;
            end
        end else if (cmd_pop && is_load) begin
            store_reg[cmd.idx[IDX_W-1:0]] <= cmd.data[LITERAL_COUNT-1:0];
        end
    end

    // partial popcounts of even and odd clauses per group
    always_comb begin
        logic [WORD_W-1:0] even_w, odd_w;
        even_w = fired_a_reg & EVEN_CLAUSES;
        odd_w  = fired_a_reg & ODD_CLAUSES;
        for (int g = 0; g < GROUPS; g++) begin
            even_part_next[g] = '0;
            odd_part_next[g]  = '0;
            for (int k = 0; k < PAIRS; k++) begin
                even_part_next[g] = even_part_next[g]
                                  + PART_W'(even_w[g * GROUP_W + 2 * k]);
                odd_part_next[g]  = odd_part_next[g]
                                  + PART_W'(odd_w[g * GROUP_W + 2 * k + 1]);
            end
        end
    end

    always_comb begin
        even_sum = '0;
        odd_sum  = '0;
        for (int g = 0; g < GROUPS; g++) begin
            even_sum = even_sum + SUM_W'(even_part_reg[g]);
            odd_sum  = odd_sum + SUM_W'(odd_part_reg[g]);
        end
        vote_raw = signed'(VOTE_W'(even_sum)) - signed'(VOTE_W'(odd_sum));
        lim      = signed'(VOTE_W'(vote_threshold));
        neg_lim  = -lim;
        if (vote_raw > lim) begin
            vote_next = lim;
        end else if (vote_raw < neg_lim) begin
            vote_next = neg_lim;
        end else begin
            vote_next = vote_raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_vld_reg <= cmd_pop && is_eval;
            end
            if (b_ready) begin
                b_vld_reg <= a_vld_reg;
            end
            if (out_ready) begin
                m_valid_reg <= b_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && cmd_pop && is_eval) begin
            fired_a_reg <= fired_next;
        end
        if (b_ready && a_vld_reg) begin
            fired_b_reg   <= fired_a_reg;
            even_part_reg <= even_part_next;
            odd_part_reg  <= odd_part_next;
        end
        if (out_ready && b_vld_reg) begin
            m_data_reg.class_vote    <= vote_next;
            m_data_reg.clauses_fired <= fired_b_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: design/tsetlin_clause_inference.sv
// tsetlin_clause_inference: top level with apb threshold register, front, queue and back
// depends on tci_pkg, tci_front, tci_fifo, tci_back
//
// input channel s_valid/s_ready/s_data carries one word per item: mode 0 loads the
// include word of clause clause_index, mode 1 evaluates literal_bits with empty clauses
// firing, mode 2 evaluates with empty clauses silent, mode 3 is taken and dropped
// each evaluate word gives one result word on m_valid/m_ready/m_data: the clamped
// vote (even minus odd firing clauses) and a fired bit per clause; loads give none
// path: an accepted word goes into the queue, then through the a, b and output registers
// throughput: one word per cycle while m_ready is high, set by the single include
// store write/evaluate step at the head of the two-word command queue
// the back pipeline holds when m_ready is low; the queue takes up to two more words,
// then s_ready drops until results drain
// apb: vote_threshold at byte address 0, written with psel, penable and pwrite high,
// pready always high; write only while the block is idle
// reset (aresetn low, synchronous): include store cleared to all excluded, threshold
// set to 16, queue and pipeline emptied
module tsetlin_clause_inference #(
    parameter int CLAUSE_COUNT  = tci_pkg::CLAUSE_COUNT_DEF,
    parameter int LITERAL_COUNT = tci_pkg::LITERAL_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tci_pkg::tci_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tci_pkg::tci_out_t              m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tci_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tci_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tci_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import tci_pkg::*;

    localparam logic [WORD_W-1:0] FIRED_MASK =
        (CLAUSE_COUNT >= WORD_W) ? '1 : ((WORD_W'(1) << CLAUSE_COUNT) - WORD_W'(1));

    logic [THR_W-1:0] threshold_reg, threshold_next;
    logic             reg_sel;
    tci_fifo_stat_t   fifo_stat;
    tci_cmd_t         front_cmd, head_cmd;
    logic             push, pop;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_VOTE_THRESHOLD);

    always_comb begin
        threshold_next = threshold_reg;
        if (psel && penable && pwrite && pready && reg_sel) begin
            threshold_next = pwdata[THR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
        end else begin
            threshold_reg <= threshold_next;
        end
    end

    assign prdata = reg_sel ? APB_DATA_W'(threshold_reg) : '0;

    tci_front #(
        .CLAUSE_COUNT(CLAUSE_COUNT)
    ) u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .fifo_stat(fifo_stat),
        .push     (push),
        .cmd      (front_cmd)
    );

    tci_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_cmd(front_cmd),
        .pop     (pop),
        .head_cmd(head_cmd),
        .stat    (fifo_stat)
    );

    tci_back #(
        .CLAUSE_COUNT (CLAUSE_COUNT),
        .LITERAL_COUNT(LITERAL_COUNT)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (!fifo_stat.empty),
        .cmd           (head_cmd),
        .cmd_pop       (pop),
        .vote_threshold(threshold_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

    // queue never written while full
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !fifo_stat.full)
        else $error("command queue written while full");

    // clauses past the configured count never fire
    a_fired_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.clauses_fired & ~FIRED_MASK) == '0))
        else $error("clause beyond range reported as fired");

    // no firing clause means a zero vote
    a_zero_vote: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.clauses_fired == '0)) |-> (m_data.class_vote == '0))
        else $error("nonzero vote with no clause fired");

    // a command is popped only from a nonempty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !fifo_stat.empty)
        else $error("command popped from empty queue");

endmodule

// File: verif/tsetlin_clause_inference_test.sv
`timescale 1ns / 100ps
// tsetlin_clause_inference_test: self-checking bench for the tsetlin clause inference block
// drives load/evaluate words, apb threshold writes and output stalls, predicts every result
// depends on tci_pkg and tsetlin_clause_inference
module tsetlin_clause_inference_test;
    import tci_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] THRESHOLD_ADDR = APB_ADDR_W'(4 * REG_VOTE_THRESHOLD);
    localparam logic [WORD_W-1:0] LIT_MASK = {WORD_W{1'b1}} >> (WORD_W - LITERAL_COUNT_DEF);
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_WORDS = 1700;
    localparam int PHASES = 10;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    tci_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    tci_out_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    logic [WORD_W-1:0] include_copy [CLAUSE_COUNT_DEF] = '{default: '0};
    logic [THR_W-1:0] vote_limit = THRESHOLD_RESET;
    tci_out_t pending_votes [$];
    int fail_count = 0;
    int cycle_count = 0;
    int hold_cycles = 0;
    bit steady = 1'b0;

    tsetlin_clause_inference dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic tci_out_t tally_clauses(input logic [WORD_W-1:0] lits,
                                               input bit silent_empty);
        tci_out_t tally;
        logic [WORD_W-1:0] inc;
        int net;
        int lim;
        tally.clauses_fired = '0;
        for (int j = 0; j < CLAUSE_COUNT_DEF; j++) begin
            inc = include_copy[j] & LIT_MASK;
            if ((inc & lits) == inc && !(silent_empty && inc == '0))
                tally.clauses_fired[j] = 1'b1;
        end
        net = $countones(tally.clauses_fired & EVEN_CLAUSES)
            - $countones(tally.clauses_fired & ODD_CLAUSES);
        lim = int'(vote_limit);
        if (net > lim) net = lim;
        if (net < -lim) net = -lim;
        tally.class_vote = VOTE_W'(net);
        return tally;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic absorb_word(input tci_in_t word);
        unique case (word.mode)
            MODE_LOAD: begin
                if (int'(word.clause_index) < CLAUSE_COUNT_DEF)
                    include_copy[word.clause_index] = word.include_bits & LIT_MASK;
            end
            MODE_EVAL_UPDATE: pending_votes.push_back(tally_clauses(word.literal_bits, 1'b0));
            MODE_EVAL_PREDICT: pending_votes.push_back(tally_clauses(word.literal_bits, 1'b1));
            default: ;
        endcase
    endtask

    task automatic check_result(input tci_out_t got);
        tci_out_t want;
        if (pending_votes.size() == 0) begin
            report_mismatch($sformatf("result word with nothing pending, vote %0d fired %h",
                                      got.class_vote, got.clauses_fired));
        end else begin
            want = pending_votes.pop_front();
            if (got.class_vote !== want.class_vote)
                report_mismatch($sformatf("class_vote %0d, want %0d",
                                          got.class_vote, want.class_vote));
            if (got.clauses_fired !== want.clauses_fired)
                report_mismatch($sformatf("clauses_fired %h, want %h",
                                          got.clauses_fired, want.clauses_fired));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) check_result(m_data);
            if (s_valid && s_ready) absorb_word(s_data);
        end
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 13);
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [WORD_W-1:0] thin_word(input int k);
        logic [WORD_W-1:0] w;
        w = rand_word();
        repeat (k - 1) w &= rand_word();
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] thick_word(input int k);
        logic [WORD_W-1:0] w;
        w = rand_word();
        repeat (k - 1) w |= rand_word();
        return w;
    endfunction

    task automatic send_word(input logic [1:0] mode, input int idx,
                             input logic [WORD_W-1:0] inc, input logic [WORD_W-1:0] lits);
        tci_in_t word;
        word.mode = mode;
        word.clause_index = IDX_FIELD_W'(idx);
        word.include_bits = inc;
        word.literal_bits = lits;
        if (!steady) begin
            while ($urandom_range(99) < 13) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_votes.size() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic write_threshold(input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= THRESHOLD_ADDR;
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        vote_limit = value[THR_W-1:0];
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic test_cleared_store();
        send_word(MODE_EVAL_UPDATE, 0, '0, '0);
        send_word(MODE_EVAL_PREDICT, 63, '1, '1);
        // unused mode carrying a load-like payload must leave the store alone
        send_word(MODE_UNUSED, 3, '1, '1);
        send_word(MODE_EVAL_PREDICT, 0, '0, '1);
    endtask

    task automatic test_load_extremes();
        send_word(MODE_LOAD, 0, '1, '0);
        send_word(MODE_LOAD, 63, 64'h1, '1);
        send_word(MODE_LOAD, 1, 64'h8000_0000_0000_0000, '0);
        send_word(MODE_LOAD, 62, '0, '1);
        send_word(MODE_EVAL_PREDICT, 0, '0, '1);
        send_word(MODE_EVAL_PREDICT, 0, '1, '0);
        send_word(MODE_EVAL_UPDATE, 0, '0, 64'h1);
        send_word(MODE_EVAL_UPDATE, 0, '0, EVEN_CLAUSES);
        send_word(MODE_EVAL_PREDICT, 0, '0, ODD_CLAUSES);
        send_word(MODE_LOAD, 0, '0, '1);
        send_word(MODE_EVAL_PREDICT, 0, '0, '1);
    endtask

    task automatic test_threshold_extremes();
        settle();
        write_threshold(32'd0);
        send_word(MODE_EVAL_PREDICT, 0, '0, '1);
        send_word(MODE_EVAL_UPDATE, 0, '0, '0);
        settle();
        write_threshold(32'd63);
        send_word(MODE_EVAL_PREDICT, 0, '0, '1);
        settle();
        write_threshold(32'd1);
        send_word(MODE_EVAL_PREDICT, 0, '0, '1);
        settle();
        write_threshold(APB_DATA_W'(THRESHOLD_RESET));
    endtask

    task automatic test_output_stall();
        hold_cycles = 80;
        repeat (24) begin
            if ($urandom_range(3) == 0)
                send_word(MODE_LOAD, $urandom_range(63), thin_word(3), rand_word());
            else
                send_word($urandom_range(1) ? MODE_EVAL_UPDATE : MODE_EVAL_PREDICT,
                          $urandom_range(63), rand_word(), thick_word(3));
        end
        settle();
    endtask

    task automatic run_random_phase(input int quota);
        int sent;
        int pick;
        int n;
        int parity;
        int bit_at;
        bit clear_rest;
        logic [WORD_W-1:0] key;
        sent = 0;
        while (sent < quota) begin
            pick = $urandom_range(99);
            if (pick < 62) begin
                n = $urandom_range(6, 1);
                repeat (n) send_word(MODE_LOAD, $urandom_range(63),
                                     thin_word($urandom_range(5, 1)), rand_word());
                sent += n;
                n = $urandom_range(4, 1);
                repeat (n) send_word($urandom_range(1) ? MODE_EVAL_UPDATE : MODE_EVAL_PREDICT,
                                     $urandom_range(63), rand_word(),
                                     thick_word($urandom_range(5, 1)));
                sent += n;
            end else if (pick < 68) begin
                // one parity shares a key literal, so the vote can swing to a full extreme
                parity = $urandom_range(1);
                bit_at = $urandom_range(WORD_W - 1);
                clear_rest = $urandom_range(1);
                key = {{(WORD_W - 1){1'b0}}, 1'b1} << bit_at;
                for (int c = 0; c < CLAUSE_COUNT_DEF; c++) begin
                    if (c % 2 == parity)
                        send_word(MODE_LOAD, c, key | thin_word(6), rand_word());
                    else if (clear_rest)
                        send_word(MODE_LOAD, c, '0, rand_word());
                end
                send_word(MODE_EVAL_UPDATE, $urandom_range(63), rand_word(), ~key);
                send_word(MODE_EVAL_PREDICT, $urandom_range(63), rand_word(), '1);
                sent += clear_rest ? CLAUSE_COUNT_DEF + 2 : CLAUSE_COUNT_DEF / 2 + 2;
            end else begin
                n = $urandom_range(3);
                send_word(2'(n), $urandom_range(63), rand_word(), rand_word());
                if (2'(n) != MODE_UNUSED) sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [THR_W-1:0] fixed_limits [5] = '{6'd16, 6'd0, 6'd1, 6'd32, 6'd63};
        logic [THR_W-1:0] limit;
        for (int p = 0; p < PHASES; p++) begin
            limit = (p < 5) ? fixed_limits[p] : THR_W'($urandom_range(31, 1));
            settle();
            write_threshold(APB_DATA_W'({$urandom, limit}));
            steady = (p == 3);
            run_random_phase(RANDOM_WORDS / PHASES);
            steady = 1'b0;
        end
    endtask

    initial begin
        int waited;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_cleared_store();
        test_load_extremes();
        test_threshold_extremes();
        test_output_stall();
        test_random_traffic();
        s_valid <= 1'b0;
        waited = 0;
        while (pending_votes.size() != 0 && waited < 5000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (12) @(negedge aclk);
        if (pending_votes.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_votes.size()));
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
